FILE: rtl/sirb_pkg.sv
// shared types and constants for the sequence id reorder buffer
// used by sirb_cell and sequence_id_reorder_buffer_unit, no dependencies
`timescale 1ns / 1ps

package sirb_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned ID_W  = 64;
  localparam int unsigned PAY_W = 64;
  localparam int unsigned REV_W = 32;
  localparam int unsigned DATA_W = 160;
  localparam int unsigned CAUSE_W = 3;

  localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

  localparam logic [CAUSE_W-1:0] CAUSE_IN_ORDER  = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_UNORDERED = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_DUPLICATE = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_LATE      = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW  = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_QUEUE     = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [REV_W-1:0] rev;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

FILE: rtl/sirb_cell.sv
// one slot of the rotating slot ring: id, payload and revision
// depends on sirb_pkg
`timescale 1ns / 1ps

module sirb_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sirb_pkg::cell_ctl_t ctl,
  input  sirb_pkg::slot_t    shift_in,
  input  sirb_pkg::slot_t    load_in,
  output sirb_pkg::slot_t    q,
  output logic               nz
);

  logic [sirb_pkg::ID_W-1:0]  id_r;
  logic [sirb_pkg::PAY_W-1:0] pay_r;
  logic [sirb_pkg::REV_W-1:0] rev_r;

  // id zero marks an empty slot, so only the id is cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= '0;
    end else if (ctl.shift) begin
      id_r <= shift_in.id;
    end else if (ctl.load) begin
      id_r <= load_in.id;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pay_r <= shift_in.payload;
      rev_r <= shift_in.rev;
    end else if (ctl.load) begin
      pay_r <= load_in.payload;
      rev_r <= load_in.rev;
    end
  end

  assign q  = '{id: id_r, payload: pay_r, rev: rev_r};
  assign nz = |id_r;

endmodule

FILE: rtl/sequence_id_reorder_buffer_unit.sv
// sequence id reorder buffer, top level with control sequencer and slot ring
// depends on sirb_pkg and sirb_cell
`timescale 1ns / 1ps

// Input channel in_*: one event per transfer, id, payload tag and revision.
// Output channel out_*: released events with a cause code in tuser; tlast
// marks the last result caused by one input event. A queued event gives
// no result.
// Id zero, duplicate, late and overflow events come out in the cycle after
// the transfer. An in-order event starts a drain: if any slot is used, the
// slot ring rotates by one cell per cycle while the output is free, and the
// head cell is compared with the expected id. Full passes repeat while a
// pass releases something. One event is handled at a time; in_tready is
// low while a drain runs. Drain results pass through a holding register
// so tlast is known before the output register is loaded. When the
// receiver stalls, the ring stops rotating and everything holds. Reset
// empties all slots and returns to the no-event-seen state; no clearing
// pass is needed.
module sequence_id_reorder_buffer_unit #(
  parameter int unsigned QUEUE_DEPTH = sirb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sirb_pkg::DATA_W-1:0] in_tdata,   // event_id, payload_tag, revision
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sirb_pkg::DATA_W-1:0] out_tdata,  // out_id, out_payload, out_revision
  output logic [sirb_pkg::CAUSE_W-1:0] out_tuser, // release_cause
  output logic                        out_tlast   // last_of_run
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [UW-1:0] USED_FULL = UW'(QUEUE_DEPTH);

  sirb_pkg::state_t state_r, state_nxt;
  logic [sirb_pkg::ID_W-1:0] hr_r, hr_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic rel_r, rel_nxt;
  sirb_pkg::slot_t held_r, held_nxt;
  logic [sirb_pkg::CAUSE_W-1:0] held_cause_r, held_cause_nxt;
  logic held_vld_r, held_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [sirb_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic [sirb_pkg::CAUSE_W-1:0] out_cause_r, out_cause_nxt;
  logic out_last_r, out_last_nxt;

  sirb_pkg::slot_t in_slot;
  sirb_pkg::slot_t q [QUEUE_DEPTH];
  sirb_pkg::slot_t wrap_slot;
  sirb_pkg::cell_ctl_t ctl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] nz_vec;

  logic out_free, in_acc, any_nz, match, do_ins;
  logic [sirb_pkg::ID_W-1:0] exp_id, id_m1, cur;

  assign in_slot = '{id: in_tdata[63:0], payload: in_tdata[127:64],
                     rev: in_tdata[159:128]};

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == sirb_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign any_nz    = |nz_vec;

  assign exp_id = hr_r + 64'd1;
  assign match  = (state_r == sirb_pkg::ST_SCAN) && nz_vec[0] && (q[0].id == exp_id);
  assign id_m1  = in_slot.id - 64'd1;
  assign cur    = (hr_r == sirb_pkg::ID_ALL_ONES) ? id_m1 : hr_r;

  // early id with room left: stored in slot used_r
  assign do_ins = in_acc && (in_slot.id != '0) && (hr_r != in_slot.id) &&
                  !(cur > id_m1) && (cur != id_m1) && (used_r < USED_FULL);

  // head cell wraps to the tail, emptied when it is released
  always_comb begin
    wrap_slot = q[0];
    if (match) begin
      wrap_slot.id = '0;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_ring
    assign ctl[i].shift = (state_r == sirb_pkg::ST_SCAN) && out_free;
    assign ctl[i].load  = do_ins && (used_r == UW'(i));
    sirb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[i]),
      .shift_in ((i == QUEUE_DEPTH - 1) ? wrap_slot : q[(i + 1) % QUEUE_DEPTH]),
      .load_in  (in_slot),
      .q        (q[i]),
      .nz       (nz_vec[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    hr_nxt         = hr_r;
    used_nxt       = used_r;
    pos_nxt        = pos_r;
    rel_nxt        = rel_r;
    held_nxt       = held_r;
    held_cause_nxt = held_cause_r;
    held_vld_nxt   = held_vld_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_cause_nxt  = out_cause_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      sirb_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_data_nxt = in_tdata;
          out_last_nxt = 1'b1;
          priority if (in_slot.id == '0) begin
            out_vld_nxt   = 1'b1;
            out_cause_nxt = sirb_pkg::CAUSE_UNORDERED;
          end else if (hr_r == in_slot.id) begin
            out_vld_nxt   = 1'b1;
            out_cause_nxt = sirb_pkg::CAUSE_DUPLICATE;
          end else if (cur > id_m1) begin
            out_vld_nxt   = 1'b1;
            out_cause_nxt = sirb_pkg::CAUSE_LATE;
          end else if (cur == id_m1) begin
            hr_nxt         = in_slot.id;
            held_nxt       = in_slot;
            held_cause_nxt = sirb_pkg::CAUSE_IN_ORDER;
            held_vld_nxt   = 1'b1;
            pos_nxt        = '0;
            rel_nxt        = 1'b0;
            state_nxt      = (used_r == '0) ? sirb_pkg::ST_FLUSH : sirb_pkg::ST_SCAN;
          end else if (used_r >= USED_FULL) begin
            out_vld_nxt   = 1'b1;
            out_cause_nxt = sirb_pkg::CAUSE_OVERFLOW;
          end else begin
            used_nxt = used_r + UW'(1);
          end
        end
      end
      sirb_pkg::ST_SCAN: begin
        if (out_free) begin
          if (match) begin
            out_vld_nxt    = 1'b1;
            out_data_nxt   = {held_r.rev, held_r.payload, held_r.id};
            out_cause_nxt  = held_cause_r;
            out_last_nxt   = 1'b0;
            held_nxt       = q[0];
            held_cause_nxt = sirb_pkg::CAUSE_QUEUE;
            hr_nxt         = q[0].id;
          end
          if (pos_r == POS_LAST) begin
            pos_nxt = '0;
            rel_nxt = 1'b0;
            if (!(rel_r || match)) begin
              if (!any_nz) begin
                used_nxt = '0;
              end
              state_nxt = sirb_pkg::ST_FLUSH;
            end
          end else begin
            pos_nxt = pos_r + PW'(1);
            rel_nxt = rel_r || match;
          end
        end
      end
      sirb_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_data_nxt  = {held_r.rev, held_r.payload, held_r.id};
          out_cause_nxt = held_cause_r;
          out_last_nxt  = 1'b1;
          held_vld_nxt  = 1'b0;
          state_nxt     = sirb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sirb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sirb_pkg::ST_IDLE;
      hr_r       <= sirb_pkg::ID_ALL_ONES;
      used_r     <= '0;
      pos_r      <= '0;
      rel_r      <= 1'b0;
      held_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hr_r       <= hr_nxt;
      used_r     <= used_nxt;
      pos_r      <= pos_nxt;
      rel_r      <= rel_nxt;
      held_vld_r <= held_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r       <= held_nxt;
    held_cause_r <= held_cause_nxt;
    out_data_r   <= out_data_nxt;
    out_cause_r  <= out_cause_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cause_r;
  assign out_tlast  = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_FULL)
    else $error("slot count beyond queue depth");

  a_held_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sirb_pkg::ST_SCAN || state_r == sirb_pkg::ST_FLUSH) |-> held_vld_r)
    else $error("drain running without a held result");

  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sirb_pkg::ST_IDLE) |-> (pos_r == '0))
    else $error("slot ring not aligned while idle");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sirb_pkg::ST_FLUSH && out_free) |=> (out_tvalid && out_tlast))
    else $error("drain ended without a last transfer");

endmodule

FILE: tb/sv/sequence_id_reorder_buffer_unit_tb.sv
// testbench for the sequence id reorder buffer: directed and random event streams
// checked against an in-bench model of the release order; depends on sirb_pkg
`timescale 1ns / 1ps

module sequence_id_reorder_buffer_unit_tb;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [sirb_pkg::ID_W-1:0]    id;
    logic [sirb_pkg::PAY_W-1:0]   payload;
    logic [sirb_pkg::REV_W-1:0]   rev;
    logic [sirb_pkg::CAUSE_W-1:0] cause;
    logic                         last;
  } release_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sirb_pkg::DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sirb_pkg::DATA_W-1:0] out_tdata;
  logic [sirb_pkg::CAUSE_W-1:0] out_tuser;
  logic out_tlast;

  sequence_id_reorder_buffer_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [sirb_pkg::ID_W-1:0]  hi_rel;
  logic [sirb_pkg::ID_W-1:0]  q_id [DEPTH];
  logic [sirb_pkg::PAY_W-1:0] q_pay [DEPTH];
  logic [sirb_pkg::REV_W-1:0] q_rev [DEPTH];
  int                         q_used;

  logic [sirb_pkg::DATA_W-1:0] event_q[$];
  release_t          release_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  stim_done = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  function automatic release_t mk(logic [sirb_pkg::ID_W-1:0] id,
                                  logic [sirb_pkg::PAY_W-1:0] p,
                                  logic [sirb_pkg::REV_W-1:0] r,
                                  logic [sirb_pkg::CAUSE_W-1:0] c);
    release_t x;
    x.id = id; x.payload = p; x.rev = r; x.cause = c; x.last = 1'b0;
    return x;
  endfunction

  task automatic predict_release(logic [sirb_pkg::DATA_W-1:0] d);
    logic [sirb_pkg::ID_W-1:0]  id;
    logic [sirb_pkg::PAY_W-1:0] p;
    logic [sirb_pkg::REV_W-1:0] r;
    logic [sirb_pkg::ID_W-1:0]  cur;
    release_t         got[$];
    bit               again;
    int               pending;
    id = d[sirb_pkg::ID_W-1:0];
    p = d[sirb_pkg::ID_W+sirb_pkg::PAY_W-1:sirb_pkg::ID_W];
    r = d[sirb_pkg::DATA_W-1:sirb_pkg::ID_W+sirb_pkg::PAY_W];
    cur = hi_rel;
    if (id == '0) got.push_back(mk(id, p, r, sirb_pkg::CAUSE_UNORDERED));
    else if (cur == id) got.push_back(mk(id, p, r, sirb_pkg::CAUSE_DUPLICATE));
    else begin
      if (cur == sirb_pkg::ID_ALL_ONES) begin
        cur = id - 1;
        hi_rel = cur;
      end
      if (cur > id - 1) got.push_back(mk(id, p, r, sirb_pkg::CAUSE_LATE));
      else if (cur == id - 1) begin
        got.push_back(mk(id, p, r, sirb_pkg::CAUSE_IN_ORDER));
        hi_rel = id;
        if (q_used > 0) begin
          do begin
            again = 1'b0;
            pending = 0;
            for (int i = 0; i < q_used; i++) begin
              if (q_id[i] == '0) continue;
              if (hi_rel != q_id[i] - 1) begin
                pending++;
                continue;
              end
              got.push_back(mk(q_id[i], q_pay[i], q_rev[i], sirb_pkg::CAUSE_QUEUE));
              hi_rel = q_id[i];
              q_id[i] = '0;
              again = 1'b1;
            end
          end while (again);
          if (pending == 0) q_used = 0;
        end
      end else if (q_used >= DEPTH) got.push_back(mk(id, p, r, sirb_pkg::CAUSE_OVERFLOW));
      else begin
        q_id[q_used] = id; q_pay[q_used] = p; q_rev[q_used] = r;
        q_used++;
      end
    end
    if (got.size() > 0) got[got.size()-1].last = 1'b1;
    foreach (got[i]) release_q.push_back(got[i]);
  endtask

  function automatic logic [sirb_pkg::DATA_W-1:0] pack_event(
      logic [sirb_pkg::ID_W-1:0] id, logic [sirb_pkg::PAY_W-1:0] p,
      logic [sirb_pkg::REV_W-1:0] r);
    return {r, p, id};
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push(logic [sirb_pkg::ID_W-1:0] id);
    event_q.push_back(pack_event(id, rnd64(), $urandom));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_release(in_tdata);
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (event_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else if (event_q.size() > 0) begin
          in_tdata <= event_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls and checking
  always @(posedge clk) begin
    release_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (release_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer id=%h", out_tdata[sirb_pkg::ID_W-1:0]);
        end else begin
          exp_r = release_q.pop_front();
          if (out_tdata !== {exp_r.rev, exp_r.payload, exp_r.id} ||
              out_tuser !== exp_r.cause || out_tlast !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp id=%h pay=%h rev=%h cause=%0d last=%0b got %h %h %h %0d %0b",
                       exp_r.id, exp_r.payload, exp_r.rev, exp_r.cause, exp_r.last,
                       out_tdata[sirb_pkg::ID_W-1:0],
                       out_tdata[sirb_pkg::ID_W+sirb_pkg::PAY_W-1:sirb_pkg::ID_W],
                       out_tdata[sirb_pkg::DATA_W-1:sirb_pkg::ID_W+sirb_pkg::PAY_W],
                       out_tuser, out_tlast);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [sirb_pkg::ID_W-1:0] base;
    int n, k;
    int order[DEPTH];
    hi_rel = sirb_pkg::ID_ALL_ONES;
    q_used = 0;
    for (int i = 0; i < DEPTH; i++) q_id[i] = '0;

    // directed: unordered, all-ones first as duplicate, start, late, queue, drain
    event_q.push_back(pack_event('0, '1, '1));
    event_q.push_back(pack_event(sirb_pkg::ID_ALL_ONES, '0, '0));
    push(64'd100);
    push(64'd100);
    push(64'd50);
    push(64'd103);
    push(64'd102);
    push(64'd103);        // same early id queued twice
    push(64'd101);        // drain releases 102 and 103, stale copy stays
    push(64'd104);
    // fill the ring until overflow
    for (int i = 0; i < DEPTH; i++) push(64'd110 + i);
    push(64'd200);        // overflow
    push(64'd105);
    // ids near all ones while the ring is still full
    push(sirb_pkg::ID_ALL_ONES - 1);
    push(64'd1);          // late
    push(sirb_pkg::ID_ALL_ONES);
    push(64'd7);          // late as well
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // random: mostly shuffled windows, some noise
    base = 64'd1000;
    for (int b = 0; b < 10; b++) begin
      n = (b == 5) ? DEPTH + 1 : $urandom_range(2, 8);
      for (int i = 0; i < n; i++) order[i % DEPTH] = i;
      for (int i = n - 1; i > 0 && i < DEPTH; i--) begin
        k = $urandom_range(0, i);
        {order[i], order[k]} = {order[k], order[i]};
      end
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: push('0);
          1: push(base + $urandom_range(0, n));
          2: push(rnd64());
          default: ;
        endcase
        push(base + ((i < DEPTH) ? order[i] : i));
      end
      base = base + n;
      if ($urandom_range(0, 4) == 0) base = base + $urandom_range(1, 20);
    end
    push(base);

    while (event_q.size() > 8) @(posedge clk);
    calm = 1'b1;
    while (event_q.size() > 0 || in_tvalid) @(posedge clk);
    while (release_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && release_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sirb_pkg.sv
rtl/sirb_cell.sv
rtl/sequence_id_reorder_buffer_unit.sv
tb/sv/sequence_id_reorder_buffer_unit_tb.sv
